@@ design/tct_pkg.sv @@
// Shared types and constants for the text console terminal.
package tct_pkg;

    // Default screen geometry
    localparam int DEF_SCREEN_ROWS = 25;
    localparam int DEF_SCREEN_COLS = 80;

    // Field widths of the transactions
    localparam int ROW_FIELD_W  = 5;
    localparam int COL_FIELD_W  = 7;
    localparam int CODE_W       = 8;
    localparam int WORD_W       = 16;

    // Operation codes
    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Character codes and cell attribute
    localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd13;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 8'h20;
    localparam logic [CODE_W-1:0] GRAY_ATTR    = 8'h07;

    typedef struct packed {
        logic                   mode;
        logic [CODE_W-1:0]      char_code;
        logic [ROW_FIELD_W-1:0] cell_row;
        logic [COL_FIELD_W-1:0] cell_col;
    } tct_in_t;

    typedef struct packed {
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
        logic [WORD_W-1:0]      cell_word;
        logic                   scrolled;
    } tct_out_t;

endpackage

@@ design/tct_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register one read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/text_console_terminal_core.sv @@
// Top level of the text console terminal: cursor sequencer and screen store.
//
//  Channel  | Signals                              | Direction | Content
//  ---------+--------------------------------------+-----------+--------------------------
//  item     | item_valid, item_ready, item         | in        | put byte or read cell
//  result   | result_valid, result_ready, result   | out       | cursor, cell word, scroll
//
// A put is accepted, then executed; a read is accepted, then the RAM is read, then
// the cell is formatted. The first character put into a row after reset or after a
// scroll blanked that row first blanks the row, cell by cell through the single RAM
// write port, and then returns to the execute state. Scrolling adds no state; the
// ring pointer moves in the put's execute state.
// Reset clears cursor, ring pointer and per-row valid bits; there is no clearing
// pass, rows not valid read as spaces. A stalled result holds the sequencer in its
// execute state; one result waits in the output register while the next item is taken.
module text_console_terminal_core #(
    parameter int SCREEN_ROWS = tct_pkg::DEF_SCREEN_ROWS,
    parameter int SCREEN_COLS = tct_pkg::DEF_SCREEN_COLS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tct_pkg::tct_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output tct_pkg::tct_out_t result
);

    import tct_pkg::*;

    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = SCREEN_ROWS * (2 ** COL_W);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLS - 1);
    localparam logic [ROW_W:0]   ROWS_EXT = (ROW_W + 1)'(SCREEN_ROWS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_CLEAR,
        ST_READ,
        ST_READ_DATA
    } state_t;

    state_t                 state_reg,     state_next;
    tct_in_t                item_reg,      item_next;
    logic [ROW_W-1:0]       row_reg,       row_next;
    logic [COL_W-1:0]       col_reg,       col_next;
    logic [ROW_W-1:0]       top_reg,       top_next;
    logic [SCREEN_ROWS-1:0] row_valid_reg, row_valid_next;
    logic [COL_W-1:0]       clr_col_reg,   clr_col_next;
    tct_out_t               result_reg,    result_next;
    logic                   result_valid_reg, result_valid_next;

    // RAM port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CODE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CODE_W-1:0] ram_rdata;

    // Put outcome
    logic             nl_scroll;
    logic [ROW_W-1:0] nl_row;
    logic [ROW_W-1:0] put_row;
    logic [COL_W-1:0] put_col;
    logic             put_scroll;
    logic             put_store;

    // Read addressing
    logic [ROW_W+ROW_FIELD_W-1:0] rd_row_ext;
    logic [COL_W+COL_FIELD_W-1:0] rd_col_ext;
    logic [ROW_W-1:0]             rd_phys;
    logic [COL_W-1:0]             rd_col;
    logic                         rd_in_range;
    logic [WORD_W-1:0]            rd_word;

    logic [ROW_W-1:0] cur_phys;
    logic             result_free;

    // Map a screen row onto its physical row in the ring
    function automatic logic [ROW_W-1:0] phys_of(input logic [ROW_W-1:0] lrow,
                                                 input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, lrow};
        if (sum >= ROWS_EXT)
        begin
            sum = sum - ROWS_EXT;
        end
        return sum[ROW_W-1:0];
    endfunction

    // Fit a row to the result field
    function automatic logic [ROW_FIELD_W-1:0] row_field(input logic [ROW_W-1:0] r);
        logic [ROW_W+ROW_FIELD_W-1:0] ext;
        ext = {{ROW_FIELD_W{1'b0}}, r};
        return ext[ROW_FIELD_W-1:0];
    endfunction

    // Fit a column to the result field
    function automatic logic [COL_FIELD_W-1:0] col_field(input logic [COL_W-1:0] c);
        logic [COL_W+COL_FIELD_W-1:0] ext;
        ext = {{COL_FIELD_W{1'b0}}, c};
        return ext[COL_FIELD_W-1:0];
    endfunction

    tct_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Locate cursor and read cell in the ring
    assign cur_phys    = phys_of(row_reg, top_reg);
    assign rd_row_ext  = {{ROW_W{1'b0}}, item_reg.cell_row};
    assign rd_col_ext  = {{COL_W{1'b0}}, item_reg.cell_col};
    assign rd_phys     = phys_of(rd_row_ext[ROW_W-1:0], top_reg);
    assign rd_col      = rd_col_ext[COL_W-1:0];
    assign rd_in_range = (32'(item_reg.cell_row) < 32'(SCREEN_ROWS)) &&
                         (32'(item_reg.cell_col) < 32'(SCREEN_COLS));
    assign ram_raddr   = {rd_phys, rd_col};

    // Format the read cell; a row not yet written reads as blank, a cell off the screen as zero
    always_comb
    begin
        rd_word = '0;
        if (rd_in_range)
        begin
            if (row_valid_reg[rd_phys])
            begin
                rd_word = {GRAY_ATTR, ram_rdata};
            end
            else
            begin
                rd_word = {GRAY_ATTR, CODE_SPACE};
            end
        end
    end

    // Work out the cursor move of a put
    always_comb
    begin
        nl_scroll  = (row_reg == LAST_ROW);
        nl_row     = nl_scroll ? row_reg : row_reg + ROW_W'(1);
        put_row    = row_reg;
        put_col    = col_reg;
        put_scroll = 1'b0;
        put_store  = 1'b0;
        priority if (item_reg.char_code == CODE_NEWLINE)
        begin
            put_row    = nl_row;
            put_col    = '0;
            put_scroll = nl_scroll;
        end
        else if (item_reg.char_code == CODE_RETURN)
        begin
            put_col = '0;
        end
        else
        begin
            put_store = 1'b1;
            if (col_reg == LAST_COL)
            begin
                put_row    = nl_row;
                put_col    = '0;
                put_scroll = nl_scroll;
            end
            else
            begin
                put_col = col_reg + COL_W'(1);
            end
        end
    end

    assign result_free = !result_valid_reg || result_ready;

    // Sequence one transaction at a time
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        top_next          = top_reg;
        row_valid_next    = row_valid_reg;
        clr_col_next      = clr_col_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        ram_we            = 1'b0;
        ram_waddr         = {cur_phys, col_reg};
        ram_wdata         = item_reg.char_code;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = (item.mode == MODE_READ) ? ST_READ : ST_PUT;
                end
            end

            ST_PUT:
            begin
                if (put_store && !row_valid_reg[cur_phys])
                begin
                    // Blank the row before its first character lands
                    clr_col_next = '0;
                    state_next   = ST_CLEAR;
                end
                else if (result_free)
                begin
                    ram_we   = put_store;
                    row_next = put_row;
                    col_next = put_col;
                    if (put_scroll)
                    begin
                        // Advance the ring; the old top row becomes the blank bottom
                        top_next                = (top_reg == LAST_ROW) ? '0
                                                  : top_reg + ROW_W'(1);
                        row_valid_next[top_reg] = 1'b0;
                    end
                    result_next.cursor_row = row_field(put_row);
                    result_next.cursor_col = col_field(put_col);
                    result_next.cell_word  = '0;
                    result_next.scrolled   = put_scroll;
                    result_valid_next      = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = {cur_phys, clr_col_reg};
                ram_wdata    = CODE_SPACE;
                clr_col_next = clr_col_reg + COL_W'(1);
                if (clr_col_reg == LAST_COL)
                begin
                    row_valid_next[cur_phys] = 1'b1;
                    state_next               = ST_PUT;
                end
            end

            ST_READ:
            begin
                // Read address is live; data arrives next cycle
                state_next = ST_READ_DATA;
            end

            ST_READ_DATA:
            begin
                if (result_free)
                begin
                    result_next.cursor_row = row_field(row_reg);
                    result_next.cursor_col = col_field(col_reg);
                    result_next.cell_word  = rd_word;
                    result_next.scrolled   = 1'b0;
                    result_valid_next      = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, cursor, ring pointer, row valid bits, clear column and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_reg          <= '0;
            col_reg          <= '0;
            top_reg          <= '0;
            row_valid_reg    <= '0;
            clr_col_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            top_reg          <= top_next;
            row_valid_reg    <= row_valid_next;
            clr_col_reg      <= clr_col_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the text console terminal core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tct_pkg::*;

    localparam int ROWS           = DEF_SCREEN_ROWS;
    localparam int COLS           = DEF_SCREEN_COLS;
    localparam int PHASE_ITEMS    = 333;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_CYCLES   = 4 * COLS;
    localparam int WATCHDOG_LIMIT = 3000;

    // Screen model: tracks cursor and cells, queues the expected result per transaction
    class console_scoreboard;
        logic [CODE_W-1:0] screen [ROWS][COLS];
        int unsigned       cur_row;
        int unsigned       cur_col;
        tct_out_t          expected_q[$];
        int unsigned       errors;

        function new();
            foreach (screen[r, c])
                screen[r][c] = CODE_SPACE;
            cur_row = 0;
            cur_col = 0;
            errors  = 0;
        endfunction

        // Go to column 0 of the next row; scroll up and blank the bottom row past the end
        function bit advance_line();
            bit did;
            did = 1'b0;
            cur_row++;
            if (cur_row >= ROWS)
            begin
                for (int r = 0; r < ROWS - 1; r++)
                    for (int c = 0; c < COLS; c++)
                        screen[r][c] = screen[r + 1][c];
                for (int c = 0; c < COLS; c++)
                    screen[ROWS - 1][c] = CODE_SPACE;
                cur_row = ROWS - 1;
                did = 1'b1;
            end
            cur_col = 0;
            return did;
        endfunction

        function void note_input(tct_in_t x);
            tct_out_t want;
            want = '0;
            if (x.mode == MODE_READ)
            begin
                if (x.cell_row < ROWS && x.cell_col < COLS)
                    want.cell_word = {GRAY_ATTR, screen[x.cell_row][x.cell_col]};
            end
            else if (x.char_code == CODE_NEWLINE)
                want.scrolled = advance_line();
            else if (x.char_code == CODE_RETURN)
                cur_col = 0;
            else
            begin
                screen[cur_row][cur_col] = x.char_code;
                cur_col++;
                if (cur_col >= COLS)
                    want.scrolled = advance_line();
            end
            want.cursor_row = ROW_FIELD_W'(cur_row);
            want.cursor_col = COL_FIELD_W'(cur_col);
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(tct_out_t got);
            tct_out_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $realtime, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
            compare_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
            compare_field("cell_word", 32'(want.cell_word), 32'(got.cell_word));
            compare_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
        endfunction
    endclass

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_ready;
    tct_in_t  item         = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    tct_out_t result;

    console_scoreboard sb = new;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request   = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    text_console_terminal_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Generate the 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drain results: random stalls, plus a long hold-off on request
    always
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            result_ready <= 1'b0;
            hold_left--;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        @(posedge clk);
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // Stop the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("text_console_terminal_core: mismatch");
                $finish;
            end
        end
    end

    function automatic tct_in_t put_item(logic [CODE_W-1:0] code);
        tct_in_t x;
        x.mode      = MODE_PUT;
        x.char_code = code;
        x.cell_row  = ROW_FIELD_W'($urandom);
        x.cell_col  = COL_FIELD_W'($urandom);
        return x;
    endfunction

    function automatic tct_in_t read_item(int unsigned row, int unsigned col);
        tct_in_t x;
        x.mode      = MODE_READ;
        x.char_code = CODE_W'($urandom);
        x.cell_row  = ROW_FIELD_W'(row);
        x.cell_col  = COL_FIELD_W'(col);
        return x;
    endfunction

    // Mostly text with line breaks and reads of visible cells; some raw bytes and stray reads
    function automatic tct_in_t random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return put_item(CODE_W'($urandom_range(8'h20, 8'h7e)));
        else if (pick < 63)
            return put_item(CODE_NEWLINE);
        else if (pick < 66)
            return put_item(CODE_RETURN);
        else if (pick < 72)
            return put_item(CODE_W'($urandom));
        else if (pick < 92)
            return read_item($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
        else
            return read_item($urandom_range(0, 31), $urandom_range(0, 127));
    endfunction

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_item(tct_in_t x);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= x;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_input(x);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Blank screen, reads past the edges, odd bytes, return and newline
        send_item(read_item(0, 0));
        send_item(read_item(ROWS - 1, COLS - 1));
        send_item(read_item(ROWS, 0));
        send_item(read_item(0, COLS));
        send_item(read_item(31, 127));
        send_item(put_item("H"));
        send_item(put_item(8'hff));
        send_item(put_item(8'h00));
        send_item(put_item(8'h80));
        send_item(read_item(0, 1));
        send_item(read_item(0, 3));
        send_item(put_item(CODE_RETURN));
        send_item(put_item("x"));
        send_item(read_item(0, 0));
        send_item(put_item(CODE_NEWLINE));
        send_item(put_item(CODE_NEWLINE));
        send_item(put_item(8'h7f));
        send_item(read_item(2, 0));
        send_item(read_item(1, 0));
        send_item(put_item(CODE_RETURN));

        // Random traffic under four idling profiles
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Back up the block with a long receiver hold-off
                if (phase == 0 && n == 100)
                    hold_request = HOLD_OFF_LEN;
                send_item(random_item());
            end
        end
        item_valid     <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("text_console_terminal_core: match");
        else
            $display("text_console_terminal_core: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/tct_pkg.sv
design/tct_ram.sv
design/text_console_terminal_core.sv
verif/testbench.sv
